// ----- rtl/css_pkg.sv -----
// package: types, constants and microcode of the control search space check
package css_pkg;

	localparam int AGL_W   = 4;
	localparam int CCE_W   = 7;
	localparam int SF_W    = 4;
	localparam int ID_W    = 16;
	localparam int HASH_W  = 17;
	localparam int PROD_W  = 33;
	localparam int CNT_W   = 5;
	localparam int PC_W    = 4;

	localparam logic [ID_W-1:0]   HASH_MULT   = 16'd39827;
	localparam logic [HASH_W:0]   HASH_MOD    = 18'd65537;
	localparam logic [CCE_W-1:0]  COMMON_CCES = 7'd16;
	localparam logic [CNT_W-1:0]  DIV_MSB     = 5'd16;
	localparam logic [CNT_W-1:0]  CANDS_LOW   = 5'd5;
	localparam logic [CNT_W-1:0]  CANDS_HIGH  = 5'd1;

	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_LOAD      = 4'd1,
		OP_CHECK     = 4'd2,
		OP_MUL       = 4'd3,
		OP_RED       = 4'd4,
		OP_DIV_INIT  = 4'd5,
		OP_DIV       = 4'd6,
		OP_CAND_INIT = 4'd7,
		OP_CAND      = 4'd8,
		OP_DONE      = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		COND_NEXT     = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_NO_START = 3'd2,
		COND_DECIDED  = 3'd3,
		COND_CNT_NZ   = 3'd4,
		COND_OUT_BUSY = 3'd5
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		logic decided;
		logic cnt_nz;
		logic out_free;
	} stat_t;

	localparam logic [PC_W-1:0] A_IDLE      = 4'd0;
	localparam logic [PC_W-1:0] A_CHECK     = 4'd1;
	localparam logic [PC_W-1:0] A_MUL       = 4'd2;
	localparam logic [PC_W-1:0] A_RED       = 4'd3;
	localparam logic [PC_W-1:0] A_DIV_INIT  = 4'd4;
	localparam logic [PC_W-1:0] A_DIV       = 4'd5;
	localparam logic [PC_W-1:0] A_CAND_INIT = 4'd6;
	localparam logic [PC_W-1:0] A_CAND      = 4'd7;
	localparam logic [PC_W-1:0] A_DONE      = 4'd8;
	localparam logic [PC_W-1:0] A_RET       = 4'd9;

	function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
		ctl_t w;
		unique case (pc)
			A_IDLE:      w = '{op: OP_LOAD,      cond: COND_NO_START, target: A_IDLE};
			A_CHECK:     w = '{op: OP_CHECK,     cond: COND_DECIDED,  target: A_DONE};
			A_MUL:       w = '{op: OP_MUL,       cond: COND_NEXT,     target: A_IDLE};
			A_RED:       w = '{op: OP_RED,       cond: COND_CNT_NZ,   target: A_MUL};
			A_DIV_INIT:  w = '{op: OP_DIV_INIT,  cond: COND_NEXT,     target: A_IDLE};
			A_DIV:       w = '{op: OP_DIV,       cond: COND_CNT_NZ,   target: A_DIV};
			A_CAND_INIT: w = '{op: OP_CAND_INIT, cond: COND_NEXT,     target: A_IDLE};
			A_CAND:      w = '{op: OP_CAND,      cond: COND_CNT_NZ,   target: A_CAND};
			A_DONE:      w = '{op: OP_DONE,      cond: COND_OUT_BUSY, target: A_DONE};
			A_RET:       w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: A_IDLE};
			default:     w = '{op: OP_NOP,       cond: COND_ALWAYS,   target: A_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/css_seq.sv -----
// microcode sequencer: step counter, control rom and jump logic
module css_seq import css_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output ctl_t  ctl,
	output logic  in_ready
);

	logic [PC_W-1:0] pc_q;
	logic            jump;

	assign ctl      = ucode(pc_q);
	assign in_ready = (ctl.op == OP_LOAD);

	always_comb begin
		unique case (ctl.cond)
			COND_NEXT:     jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_NO_START: jump = !in_valid;
			COND_DECIDED:  jump = stat.decided;
			COND_CNT_NZ:   jump = stat.cnt_nz;
			COND_OUT_BUSY: jump = !stat.out_free;
			default:       jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else if (jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

endmodule

// ----- rtl/css_datapath.sv -----
// datapath: operand registers, hash multiply and reduce, serial modulo, candidate scan
module css_datapath import css_pkg::*; #(
	parameter int MAX_CCES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             ctl,
	input  logic             in_take,
	input  logic [AGL_W-1:0] aggregation_level,
	input  logic [CCE_W-1:0] cce_count,
	input  logic [SF_W-1:0]  subframe_number,
	input  logic [ID_W-1:0]  identifier,
	input  logic [CCE_W-1:0] first_cce,
	input  logic             out_ready,
	output stat_t            stat,
	output logic             out_valid,
	output logic             in_search_space
);

	logic [AGL_W-1:0]  agl_q;
	logic [CCE_W-1:0]  ncce_q;
	logic [CCE_W-1:0]  start_q;
	logic [HASH_W-1:0] y_q;
	logic [PROD_W-1:0] prod_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CCE_W-1:0]  rem_q;
	logic [CCE_W-1:0]  cand_q;
	logic              hit_q;
	logic              out_valid_q;
	logic              out_bit_q;

	logic [CCE_W-1:0]  ncce_sat;
	logic              legal;
	logic [1:0]        lg;
	logic [CCE_W-1:0]  mask;
	logic [CCE_W-1:0]  blocks;
	logic [CCE_W-1:0]  start_blk;
	logic              aligned;
	logic [CCE_W-1:0]  css;
	logic              common_hit;
	logic              decided;
	logic              decided_hit;
	logic [HASH_W:0]   red_diff;
	logic [HASH_W-1:0] red_y;
	logic [CCE_W:0]    trial;
	logic [CCE_W-1:0]  rem_next;
	logic [CCE_W:0]    cand_inc;
	logic              cand_match;
	logic              out_free;

	assign ncce_sat = ({2'b00, cce_count} > 9'(MAX_CCES)) ? CCE_W'(MAX_CCES) : cce_count;

	always_comb begin
		unique case (agl_q)
			4'd1:    begin legal = 1'b1; lg = 2'd0; end
			4'd2:    begin legal = 1'b1; lg = 2'd1; end
			4'd4:    begin legal = 1'b1; lg = 2'd2; end
			4'd8:    begin legal = 1'b1; lg = 2'd3; end
			default: begin legal = 1'b0; lg = 2'd0; end
		endcase
	end

	assign mask        = (CCE_W'(1) << lg) - CCE_W'(1);
	assign blocks      = ncce_q >> lg;
	assign start_blk   = start_q >> lg;
	assign aligned     = ((start_q & mask) == '0);
	assign css         = (ncce_q < COMMON_CCES) ? ncce_q : COMMON_CCES;
	assign common_hit  = aligned && (({1'b0, start_q} + {4'b0000, agl_q}) <= {1'b0, css});
	assign decided     = !legal || (blocks == '0) || common_hit;
	assign decided_hit = legal && (blocks != '0) && common_hit;

	// 2^16 = -1 mod 65537
	assign red_diff = {2'b00, prod_q[15:0]} - {1'b0, prod_q[PROD_W-1:16]};
	assign red_y    = red_diff[HASH_W] ? HASH_W'(red_diff + HASH_MOD) : red_diff[HASH_W-1:0];

	assign trial    = {rem_q, y_q[cnt_q]};
	assign rem_next = (trial >= {1'b0, blocks}) ? CCE_W'(trial - {1'b0, blocks}) : trial[CCE_W-1:0];

	assign cand_inc   = {1'b0, cand_q} + 1'b1;
	assign cand_match = aligned && (start_blk == cand_q);

	assign out_free = !out_valid_q || out_ready;

	assign stat.decided  = decided;
	assign stat.cnt_nz   = (cnt_q != '0);
	assign stat.out_free = out_free;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (in_take) begin
					agl_q   <= aggregation_level;
					ncce_q  <= ncce_sat;
					start_q <= first_cce;
					y_q     <= {1'b0, identifier};
					cnt_q   <= {1'b0, subframe_number};
				end
			end
			OP_CHECK: begin
				hit_q <= decided_hit;
			end
			OP_MUL: begin
				prod_q <= PROD_W'(y_q) * PROD_W'(HASH_MULT);
			end
			OP_RED: begin
				y_q   <= red_y;
				cnt_q <= cnt_q - 1'b1;
			end
			OP_DIV_INIT: begin
				rem_q <= '0;
				cnt_q <= DIV_MSB;
			end
			OP_DIV: begin
				rem_q <= rem_next;
				cnt_q <= cnt_q - 1'b1;
			end
			OP_CAND_INIT: begin
				cand_q <= rem_q;
				cnt_q  <= agl_q[3:2] != 2'b00 ? CANDS_HIGH : CANDS_LOW;
			end
			OP_CAND: begin
				if (cand_match) begin
					hit_q <= 1'b1;
				end
				cand_q <= (cand_inc == {1'b0, blocks}) ? '0 : cand_inc[CCE_W-1:0];
				cnt_q  <= cnt_q - 1'b1;
			end
			OP_NOP, OP_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.op == OP_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_DONE && out_free) begin
			out_bit_q <= hit_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign in_search_space = out_bit_q;

endmodule

// ----- rtl/control_search_space_check_core.sv -----
// top level: control-channel search space check
//
// input channel: in_valid/in_ready with aggregation_level, cce_count,
// subframe_number, identifier and first_cce; one transfer per check
// output channel: out_valid/out_ready with in_search_space, one transfer
// per input transfer, in order
// a microcode sequencer steps a small datapath: level and common space
// check, then subframe_number+1 hash rounds (each a multiply, then a
// reduce mod 65537), a bit-serial modulo of the 17-bit hash by the block
// count, and a scan of 6 (levels 1, 2) or 2 (levels 4, 8) candidates
// an illegal level, too few CCEs for one block or a hit in the common
// space decides the check at once and skips the hash, modulo and scan;
// one check at a time: after the final step registers the result, the
// sequencer passes a return step and then raises in_ready again for
// another input transfer
// the result sits in an output register; a stalled receiver holds the
// sequencer at its final step until that register frees up
// reset clears the step counter and the output valid; nothing else is kept
module control_search_space_check_core import css_pkg::*; #(
	parameter int MAX_CCES = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [AGL_W-1:0] aggregation_level,
	input  logic [CCE_W-1:0] cce_count,
	input  logic [SF_W-1:0]  subframe_number,
	input  logic [ID_W-1:0]  identifier,
	input  logic [CCE_W-1:0] first_cce,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             in_search_space
);

	ctl_t  ctl;
	stat_t stat;

	css_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.ctl      (ctl),
		.in_ready (in_ready)
	);

	css_datapath #(
		.MAX_CCES (MAX_CCES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.in_take           (in_valid && in_ready),
		.aggregation_level (aggregation_level),
		.cce_count         (cce_count),
		.subframe_number   (subframe_number),
		.identifier        (identifier),
		.first_cce         (first_cce),
		.out_ready         (out_ready),
		.stat              (stat),
		.out_valid         (out_valid),
		.in_search_space   (in_search_space)
	);

endmodule
